FILE: sv/qsu_pkg.sv
// Shared types, codes and helper functions of the quoted string unescaper.
package qsu_pkg;

    typedef enum logic [2:0] {
        KIND_WAIT = 3'd0,
        KIND_SQ   = 3'd1,
        KIND_DQ   = 3'd2,
        KIND_BQ   = 3'd3,
        KIND_PASS = 3'd4,
        KIND_DONE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_TEXT  = 3'd0,
        ST_BSL   = 3'd1,
        ST_OCT   = 3'd2,
        ST_HEX   = 3'd3,
        ST_UCS   = 3'd4,
        ST_QPEND = 3'd5
    } t_scan;

    localparam int unsigned MAX_RES = 7;

    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_BQ  = 8'h60;
    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_ESC = 8'd27;

    // Scanner state that does not depend on the counter width.
    typedef struct packed {
        t_kind        kind;
        t_scan        scan;
        logic [3:0]   digits_left;
        logic [31:0]  esc_val;
        logic         any_digit;
        logic [7:0]   esc_letter;
        logic         err;
    } t_state;

    // Bytes produced by one input item while it is decoded.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              n;
        logic                    err;
    } t_acc;

    // Everything the output stage needs to play out one item's results.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              n;
        logic                    closed;
        logic                    bad;
        logic [15:0]             count;
        logic [15:0]             offset;
    } t_res;

    function automatic t_acc push_byte(t_acc a, logic [7:0] b);
        t_acc r;
        r = a;
        if (r.n < 3'(MAX_RES)) begin
            r.bytes[r.n] = b;
            r.n          = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic t_acc put_byte(t_acc a, logic [31:0] v, logic [7:0] min_char);
        t_acc r;
        r = a;
        if (v[7:0] < min_char) begin
            r.err = 1'b1;
        end
        if (!r.err) begin
            r = push_byte(r, v[7:0]);
        end
        return r;
    endfunction

    // UTF-8 of up to six bytes; code points above 31 bits emit nothing.
    function automatic t_acc put_utf8(t_acc a, logic [31:0] v, logic [7:0] min_char);
        t_acc       r;
        logic [2:0] nn;
        logic [7:0] lead;
        logic       ok;
        r    = a;
        nn   = 3'd0;
        lead = 8'h00;
        ok   = 1'b1;
        if (v < {24'd0, min_char}) begin
            r.err = 1'b1;
        end
        if (!r.err) begin
            if (v <= 32'h7f) begin
                r  = push_byte(r, v[7:0]);
                ok = 1'b0;
            end else if (v < 32'h800) begin
                nn = 3'd1; lead = 8'hc0;
            end else if (v < 32'h10000) begin
                nn = 3'd2; lead = 8'he0;
            end else if (v < 32'h200000) begin
                nn = 3'd3; lead = 8'hf0;
            end else if (v < 32'h4000000) begin
                nn = 3'd4; lead = 8'hf8;
            end else if (v < 32'h80000000) begin
                nn = 3'd5; lead = 8'hfc;
            end else begin
                ok = 1'b0;
            end
            if (ok) begin
                r = push_byte(r, lead | 8'(v >> (6 * nn)));
                for (int i = 5; i >= 1; i--) begin
                    if (3'(i) <= nn) begin
                        r = push_byte(r, 8'h80 | {2'b00, 6'(v >> (6 * (i - 1)))});
                    end
                end
            end
        end
        return r;
    endfunction

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: sv/qsu_in_if.sv
// Valid/ready channel that carries one text byte or an end-of-text marker.
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

FILE: sv/qsu_out_if.sv
// Valid/ready channel that carries one decoded result with its status fields.
interface qsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        closed;
    logic        bad_char;
    logic [15:0] out_count;
    logic [15:0] close_offset;

    modport source (
        output valid, output out_byte, output byte_valid, output last_of_run,
        output closed, output bad_char, output out_count, output close_offset,
        input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input last_of_run,
        input closed, input bad_char, input out_count, input close_offset,
        output ready
    );
endinterface

FILE: sv/quoted_string_unescaper_core.sv
// Quoted string unescaper: input register, decode logic, result register and state.
//
// Usage: a text arrives on i_in one byte per transaction; its first byte selects single
// quote, double quote, backquote escape or pass-through mode. A transaction with
// end_of_text set carries no byte, flushes any pending escape and rearms the block.
// Each input transaction produces one to seven results on o_out: one per emitted byte,
// or a single status-only result when no byte comes out. last_of_run marks the final
// result of an input transaction. i_cfg_wr_en / i_cfg_wr_data write min_allowed_char
// and must only be used while the block is idle.
// An accepted transaction is held in the input register until the result register takes
// its decode; the result register then presents the first result on o_out.
// Throughput: one input transaction per cycle while each yields a single result and
// o_out.ready is high; an item with N results holds the result register for N output
// transactions; the input register takes one more transaction before i_in.ready drops.
// Reset clears both pipeline valid flags, the scanner state and min_allowed_char.
// When o_out.ready is low the current result holds and the input side backs up.
module quoted_string_unescaper_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qsu_in_if.sink      i_in,
    qsu_out_if.source   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_end;
    logic [7:0]             r_min;

    qsu_pkg::t_state        r_st;
    logic [COUNT_WIDTH-1:0] r_emitted;
    logic [COUNT_WIDTH-1:0] r_in_pos;
    logic [COUNT_WIDTH-1:0] r_close_pos;

    qsu_pkg::t_state        n_st;
    logic [COUNT_WIDTH-1:0] n_emitted;
    logic [COUNT_WIDTH-1:0] n_in_pos;
    logic [COUNT_WIDTH-1:0] n_close_pos;

    qsu_pkg::t_res          res;
    logic                   emit_ready;
    logic                   advance;

    assign advance    = r_in_valid && emit_ready;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 8'd0;
        end else if (i_cfg_wr_en) begin
            r_min <= i_cfg_wr_data;
        end
    end

    // Scanner state moves on when the item in the input register enters the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '{kind: qsu_pkg::KIND_WAIT, scan: qsu_pkg::ST_TEXT, default: '0};
            r_emitted   <= '0;
            r_in_pos    <= '0;
            r_close_pos <= '0;
        end else if (advance) begin
            r_st        <= n_st;
            r_emitted   <= n_emitted;
            r_in_pos    <= n_in_pos;
            r_close_pos <= n_close_pos;
        end
    end

    qsu_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_st        (r_st),
        .i_emitted   (r_emitted),
        .i_in_pos    (r_in_pos),
        .i_close_pos (r_close_pos),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .i_min       (r_min),
        .o_st        (n_st),
        .o_emitted   (n_emitted),
        .o_in_pos    (n_in_pos),
        .o_close_pos (n_close_pos),
        .o_res       (res)
    );

    qsu_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_res        (res),
        .o_load_ready (emit_ready),
        .o_out        (o_out)
    );

endmodule

FILE: sv/qsu_decode.sv
// Combinational decode of one input item: next scanner state and produced bytes.
module qsu_decode #(
    parameter int COUNT_WIDTH = 16
) (
    input  qsu_pkg::t_state          i_st,
    input  logic [COUNT_WIDTH-1:0]   i_emitted,
    input  logic [COUNT_WIDTH-1:0]   i_in_pos,
    input  logic [COUNT_WIDTH-1:0]   i_close_pos,
    input  logic [7:0]               i_byte,
    input  logic                     i_end,
    input  logic [7:0]               i_min,
    output qsu_pkg::t_state          o_st,
    output logic [COUNT_WIDTH-1:0]   o_emitted,
    output logic [COUNT_WIDTH-1:0]   o_in_pos,
    output logic [COUNT_WIDTH-1:0]   o_close_pos,
    output qsu_pkg::t_res            o_res
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    qsu_pkg::t_acc            acc;
    qsu_pkg::t_state          ns;
    logic [COUNT_WIDTH-1:0]   close_pos;
    logic [COUNT_WIDTH-1:0]   in_pos;
    logic [COUNT_WIDTH:0]     emit_sum;
    logic [COUNT_WIDTH-1:0]   emitted;
    logic                     do_start;
    logic                     closed;
    logic [7:0]               quote;
    logic [7:0]               esc_byte;
    logic [4:0]               hex;
    logic [3:0]               dl;

    function automatic qsu_pkg::t_acc flush_acc(qsu_pkg::t_acc a, qsu_pkg::t_state s,
                                                logic [7:0] min_char);
        qsu_pkg::t_acc r;
        r = a;
        unique case (s.scan)
            qsu_pkg::ST_OCT: r = qsu_pkg::put_byte(r, s.esc_val, min_char);
            qsu_pkg::ST_HEX: r = qsu_pkg::put_byte(r, s.any_digit ? s.esc_val
                                                      : {24'd0, s.esc_letter}, min_char);
            qsu_pkg::ST_UCS: begin
                if (s.any_digit) begin
                    r = qsu_pkg::put_utf8(r, s.esc_val, min_char);
                end else begin
                    r = qsu_pkg::put_byte(r, {24'd0, s.esc_letter}, min_char);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always_comb begin
        acc       = '0;
        acc.err   = i_st.err;
        ns        = i_st;
        close_pos = i_close_pos;
        in_pos    = i_in_pos;
        do_start  = 1'b0;
        closed    = 1'b0;
        quote     = (i_st.kind == qsu_pkg::KIND_SQ) ? qsu_pkg::CH_SQ : qsu_pkg::CH_DQ;
        esc_byte  = i_byte;
        hex       = qsu_pkg::hex_value(i_byte);
        dl        = i_st.digits_left;

        if (i_end) begin
            if (i_st.kind == qsu_pkg::KIND_BQ) begin
                acc     = flush_acc(acc, i_st, i_min);
                ns.scan = qsu_pkg::ST_TEXT;
            end
            if (i_st.kind != qsu_pkg::KIND_DONE &&
                !((i_st.kind == qsu_pkg::KIND_SQ || i_st.kind == qsu_pkg::KIND_DQ) &&
                  i_st.scan == qsu_pkg::ST_QPEND)) begin
                close_pos = i_in_pos;
            end
            closed = 1'b1;
        end else begin
            unique case (i_st.kind)
                qsu_pkg::KIND_WAIT: begin
                    if (i_byte == qsu_pkg::CH_SQ) begin
                        ns.kind = qsu_pkg::KIND_SQ;
                    end else if (i_byte == qsu_pkg::CH_DQ) begin
                        ns.kind = qsu_pkg::KIND_DQ;
                    end else if (i_byte == qsu_pkg::CH_BQ) begin
                        ns.kind = qsu_pkg::KIND_BQ;
                    end else begin
                        ns.kind = qsu_pkg::KIND_PASS;
                        acc     = qsu_pkg::put_byte(acc, {24'd0, i_byte}, i_min);
                    end
                    ns.scan = qsu_pkg::ST_TEXT;
                end
                qsu_pkg::KIND_SQ, qsu_pkg::KIND_DQ: begin
                    if (i_st.scan == qsu_pkg::ST_QPEND) begin
                        if (i_byte == quote) begin
                            acc     = qsu_pkg::put_byte(acc, {24'd0, quote}, i_min);
                            ns.scan = qsu_pkg::ST_TEXT;
                        end else begin
                            ns.kind = qsu_pkg::KIND_DONE;
                        end
                    end else if (i_byte == quote) begin
                        close_pos = i_in_pos;
                        ns.scan   = qsu_pkg::ST_QPEND;
                    end else begin
                        acc = qsu_pkg::put_byte(acc, {24'd0, i_byte}, i_min);
                    end
                end
                qsu_pkg::KIND_BQ: begin
                    unique case (i_st.scan)
                        qsu_pkg::ST_BSL: begin
                            ns.scan       = qsu_pkg::ST_TEXT;
                            ns.esc_letter = i_byte;
                            ns.esc_val    = 32'd0;
                            ns.any_digit  = 1'b0;
                            unique case (i_byte)
                                "a": esc_byte = 8'd7;
                                "b": esc_byte = 8'd8;
                                "e": esc_byte = qsu_pkg::CH_ESC;
                                "f": esc_byte = 8'd12;
                                "n": esc_byte = 8'd10;
                                "r": esc_byte = 8'd13;
                                "t": esc_byte = 8'd9;
                                "v": esc_byte = 8'd11;
                                "u": begin
                                    ns.scan        = qsu_pkg::ST_UCS;
                                    ns.digits_left = 4'd4;
                                end
                                "U": begin
                                    ns.scan        = qsu_pkg::ST_UCS;
                                    ns.digits_left = 4'd8;
                                end
                                "x", "X": begin
                                    ns.scan        = qsu_pkg::ST_HEX;
                                    ns.digits_left = 4'd2;
                                end
                                default: begin
                                    if (i_byte >= "0" && i_byte <= "7") begin
                                        ns.scan        = qsu_pkg::ST_OCT;
                                        ns.digits_left = 4'd2;
                                        ns.esc_val     = {29'd0, i_byte[2:0]};
                                        ns.any_digit   = 1'b1;
                                    end
                                end
                            endcase
                            if (ns.scan == qsu_pkg::ST_TEXT) begin
                                acc = qsu_pkg::put_byte(acc, {24'd0, esc_byte}, i_min);
                            end
                        end
                        qsu_pkg::ST_OCT: begin
                            if (i_byte >= "0" && i_byte <= "7") begin
                                ns.esc_val = {i_st.esc_val[28:0], 3'd0} +
                                             {29'd0, i_byte[2:0]};
                                if (dl != 4'd0) begin
                                    dl = dl - 4'd1;
                                end
                                ns.digits_left = dl;
                                if (dl == 4'd0) begin
                                    acc     = qsu_pkg::put_byte(acc, ns.esc_val, i_min);
                                    ns.scan = qsu_pkg::ST_TEXT;
                                end
                            end else begin
                                acc      = flush_acc(acc, i_st, i_min);
                                ns.scan  = qsu_pkg::ST_TEXT;
                                do_start = 1'b1;
                            end
                        end
                        qsu_pkg::ST_HEX, qsu_pkg::ST_UCS: begin
                            if (hex[4]) begin
                                ns.esc_val   = {i_st.esc_val[27:0], hex[3:0]};
                                ns.any_digit = 1'b1;
                                if (dl != 4'd0) begin
                                    dl = dl - 4'd1;
                                end
                                ns.digits_left = dl;
                                if (dl == 4'd0) begin
                                    if (i_st.scan == qsu_pkg::ST_HEX) begin
                                        acc = qsu_pkg::put_byte(acc, ns.esc_val, i_min);
                                    end else begin
                                        acc = qsu_pkg::put_utf8(acc, ns.esc_val, i_min);
                                    end
                                    ns.scan = qsu_pkg::ST_TEXT;
                                end
                            end else begin
                                acc      = flush_acc(acc, i_st, i_min);
                                ns.scan  = qsu_pkg::ST_TEXT;
                                do_start = 1'b1;
                            end
                        end
                        default: begin
                            ns.scan  = qsu_pkg::ST_TEXT;
                            do_start = 1'b1;
                        end
                    endcase
                end
                qsu_pkg::KIND_PASS: acc = qsu_pkg::put_byte(acc, {24'd0, i_byte}, i_min);
                default: ;
            endcase

            // Text byte of an escaped string, also the byte that ended a short escape.
            if (do_start) begin
                if (i_byte == qsu_pkg::CH_BSL) begin
                    ns.scan = qsu_pkg::ST_BSL;
                end else if (i_byte == qsu_pkg::CH_BQ) begin
                    close_pos = i_in_pos;
                    ns.kind   = qsu_pkg::KIND_DONE;
                end else begin
                    acc = qsu_pkg::put_byte(acc, {24'd0, i_byte}, i_min);
                end
            end

            in_pos = (i_in_pos < CountMax) ? i_in_pos + 1'b1 : i_in_pos;
            closed = (ns.kind == qsu_pkg::KIND_DONE);
        end

        ns.err   = acc.err;
        emit_sum = {1'b0, i_emitted} + (COUNT_WIDTH+1)'(acc.n);
        emitted  = (emit_sum > {1'b0, CountMax}) ? CountMax : emit_sum[COUNT_WIDTH-1:0];

        o_res.bytes  = acc.bytes;
        o_res.n      = acc.n;
        o_res.closed = closed;
        o_res.bad    = acc.err;
        o_res.count  = 16'(emitted);
        o_res.offset = closed ? 16'(close_pos) : 16'd0;

        // The end of a text rearms everything but the configuration register.
        if (i_end) begin
            o_st        = '{kind: qsu_pkg::KIND_WAIT, scan: qsu_pkg::ST_TEXT, default: '0};
            o_emitted   = '0;
            o_in_pos    = '0;
            o_close_pos = '0;
        end else begin
            o_st        = ns;
            o_emitted   = emitted;
            o_in_pos    = in_pos;
            o_close_pos = close_pos;
        end
    end

endmodule

FILE: sv/qsu_emit.sv
// Result register that plays out the bytes of one decoded item, one per transaction.
module qsu_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  qsu_pkg::t_res      i_res,
    output logic               o_load_ready,
    qsu_out_if.source          o_out
);

    logic          r_valid;
    logic [2:0]    r_idx;
    qsu_pkg::t_res r_res;
    logic          last;
    logic          take;
    logic          load;

    assign last         = (r_res.n == 3'd0) || (r_idx == r_res.n - 3'd1);
    assign take         = r_valid && o_out.ready;
    assign o_load_ready = !r_valid || (take && last);
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = (r_res.n != 3'd0) ? r_res.bytes[r_idx] : 8'd0;
    assign o_out.byte_valid   = (r_res.n != 3'd0);
    assign o_out.last_of_run  = last;
    assign o_out.closed       = r_res.closed;
    assign o_out.bad_char     = r_res.bad;
    assign o_out.out_count    = r_res.count;
    assign o_out.close_offset = r_res.offset;

endmodule
